@@ rtl/rsef_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rsef_pkg - shared types and constants
// Register indexes, sequencer states and datapath widths of the rational
// scaler with remainder carry.
// ============================================================================
package rsef_pkg;

    localparam int ACC_W      = 64;             // datapath / result width
    localparam int REG_W      = 32;             // config register width
    localparam int CFG_IDX_W  = 8;              // config index width
    localparam int MUL_STEPS  = REG_W;          // one multiplier bit per cycle
    localparam int DIV_STEPS  = ACC_W;          // one quotient bit per cycle
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DENOMINATOR = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRY       = 8'd3;

    typedef struct packed {
        logic signed [REG_W-1:0] numerator;
        logic signed [REG_W-1:0] denominator;
        logic signed [REG_W-1:0] center;
        logic                    carry;
    } t_cfg;

    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_ADDREM,
        ST_ABST,
        ST_ABSD,
        ST_DIV,
        ST_NEGQ,
        ST_NEGR,
        ST_ADDC
    } t_state;

endpackage

@@ rtl/rsef_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rsef_if - stream and config channels
// Valid/ready channels for samples, results and register writes.
// ============================================================================
interface rsef_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface rsef_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [rsef_pkg::ACC_W-1:0]  scaled_value;

    modport source (output valid, output scaled_value, input ready);
    modport sink   (input valid, input scaled_value, output ready);
endinterface

interface rsef_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rsef_pkg::CFG_IDX_W-1:0]    index;
    logic [rsef_pkg::REG_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/rsef_cfg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rsef_cfg - configuration registers
// Holds numerator, denominator, center and carry enable; always ready.
// ============================================================================
module rsef_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rsef_cfg_if.sink          i_cfg,
    output rsef_pkg::t_cfg    o_cfg
);

    rsef_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.numerator   <= rsef_pkg::REG_W'(1);
            r_cfg.denominator <= rsef_pkg::REG_W'(1);
            r_cfg.center      <= '0;
            r_cfg.carry       <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rsef_pkg::CFG_NUMERATOR:   r_cfg.numerator   <= i_cfg.data;
                rsef_pkg::CFG_DENOMINATOR: r_cfg.denominator <= i_cfg.data;
                rsef_pkg::CFG_CENTER:      r_cfg.center      <= i_cfg.data;
                rsef_pkg::CFG_CARRY:       r_cfg.carry       <= i_cfg.data[0];
                default: ;  // unknown index: dropped
            endcase
        end
    end

endmodule

@@ rtl/rsef_alu.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rsef_alu - shared 64-bit adder/subtractor
// The one arithmetic unit that every sequencer step goes through.
// ============================================================================
module rsef_alu (
    input  rsef_pkg::t_alu_req          i_req,
    output logic [rsef_pkg::ACC_W-1:0]  o_sum
);

    logic [rsef_pkg::ACC_W-1:0] w_b;

    // a - b as a + ~b + 1
    assign w_b   = i_req.sub ? ~i_req.b : i_req.b;
    assign o_sum = i_req.a + w_b + rsef_pkg::ACC_W'(i_req.sub);

endmodule

@@ rtl/rational_scaler_error_feedback_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rational_scaler_error_feedback_top - rational scaler with remainder carry
// Scales a signed sample about a center by numerator/denominator, carrying
// the division remainder from item to item when enabled.
// ============================================================================
//
//  Channel    Dir  Handshake      Payload
//  ---------  ---  -------------  --------------------------------------------
//  i_sample   in   valid/ready    sample_value, VALUE_WIDTH bits signed
//  o_result   out  valid/ready    scaled_value, 64 bits signed
//  i_cfg      in   valid/ready    index (8 bits), data (32 bits)
//
//  Steps: with a nonzero denominator an item goes from accept to result
//  register through 1 center subtract, 32 shift-add multiply steps,
//  1 remainder add, 2 sign fixes, 64 restoring divide steps, 2 negations
//  and 1 center add; a zero denominator skips from the remainder add to
//  the center add. All go through the single 64-bit adder. The sequencer
//  returns to idle, ready for the next item, when the result is loaded.
//  Reset: synchronous, active low; clears sequencer, result valid, carried
//  remainder and config registers (numerator 1, denominator 1).
//  Stalls: the result register frees the sequencer; a new item may be in
//  work while the previous result waits. Only the final load waits on it.
// ============================================================================
module rational_scaler_error_feedback_top #(
    parameter int VALUE_WIDTH = 32      // sample width, 8..32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rsef_in_if.sink                    i_sample,
    rsef_out_if.source                 o_result,
    rsef_cfg_if.sink                   i_cfg
);

    localparam int AW = rsef_pkg::ACC_W;
    localparam int RW = rsef_pkg::REG_W;
    localparam int CW = rsef_pkg::CNT_W;

    rsef_pkg::t_cfg     w_cfg;
    rsef_pkg::t_alu_req w_req;
    logic [AW-1:0]      w_sum;

    // sequencer and datapath registers
    rsef_pkg::t_state   r_state,   n_state;
    logic [AW-1:0]      r_acc,     n_acc;       // running value / dividend+quotient
    logic [AW-1:0]      r_mcand,   n_mcand;     // shifted multiplicand
    logic [RW-1:0]      r_mplier,  n_mplier;    // multiplier bits, LSB first
    logic [CW-1:0]      r_cnt,     n_cnt;
    logic [RW-1:0]      r_rem,     n_rem;       // partial remainder (magnitude)
    logic [RW-1:0]      r_md,      n_md;        // divisor magnitude
    logic               r_tn,      n_tn;        // dividend negative
    logic               r_dn,      n_dn;        // divisor negative
    logic [RW-1:0]      r_carried, n_carried;   // remainder kept between items
    logic               r_out_vld, n_out_vld;
    logic [AW-1:0]      r_out,     n_out;

    logic [RW:0]        w_shl;                  // remainder with next dividend bit
    logic               w_ge;
    logic               w_out_free;

    rsef_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    rsef_alu u_alu (
        .i_req (w_req),
        .o_sum (w_sum)
    );

    assign w_shl      = {r_rem, r_acc[AW-1]};
    assign w_ge       = ~w_sum[AW-1];           // shifted remainder >= divisor
    assign w_out_free = ~r_out_vld | o_result.ready;

    assign i_sample.ready        = (r_state == rsef_pkg::ST_IDLE);
    assign o_result.valid        = r_out_vld;
    assign o_result.scaled_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rsef_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
            r_carried <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_carried <= n_carried;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_md     <= n_md;
        r_tn     <= n_tn;
        r_dn     <= n_dn;
        r_out    <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_mcand   = r_mcand;
        n_mplier  = r_mplier;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_md      = r_md;
        n_tn      = r_tn;
        n_dn      = r_dn;
        n_carried = r_carried;
        n_out     = r_out;
        n_out_vld = r_out_vld & ~o_result.ready;
        w_req.a   = r_acc;
        w_req.b   = '0;
        w_req.sub = 1'b0;

        case (r_state)
            rsef_pkg::ST_IDLE: begin
                if (i_sample.valid) begin
                    n_acc   = {{(AW-VALUE_WIDTH){i_sample.sample_value[VALUE_WIDTH-1]}},
                               i_sample.sample_value};
                    n_state = rsef_pkg::ST_DIFF;
                end
            end
            rsef_pkg::ST_DIFF: begin
                // sample - center
                w_req.b   = {{(AW-RW){w_cfg.center[RW-1]}}, w_cfg.center};
                w_req.sub = 1'b1;
                n_mcand   = w_sum;
                n_acc     = '0;
                n_mplier  = w_cfg.numerator;
                n_cnt     = '0;
                n_state   = rsef_pkg::ST_MUL;
            end
            rsef_pkg::ST_MUL: begin
                // sign bit of the numerator weighs -2^31: subtract on the last step
                w_req.b   = r_mplier[0] ? r_mcand : '0;
                w_req.sub = (r_cnt == CW'(rsef_pkg::MUL_STEPS - 1));
                n_acc     = w_sum;
                n_mcand   = {r_mcand[AW-2:0], 1'b0};
                n_mplier  = {1'b0, r_mplier[RW-1:1]};
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CW'(rsef_pkg::MUL_STEPS - 1)) begin
                    n_state = rsef_pkg::ST_ADDREM;
                end
            end
            rsef_pkg::ST_ADDREM: begin
                w_req.b = w_cfg.carry ? {{(AW-RW){r_carried[RW-1]}}, r_carried} : '0;
                n_acc   = w_sum;
                n_state = (w_cfg.denominator != '0) ? rsef_pkg::ST_ABST
                                                    : rsef_pkg::ST_ADDC;
            end
            rsef_pkg::ST_ABST: begin
                w_req.a   = '0;
                w_req.b   = r_acc;
                w_req.sub = 1'b1;
                n_tn      = r_acc[AW-1];
                n_dn      = w_cfg.denominator[RW-1];
                n_acc     = r_acc[AW-1] ? w_sum : r_acc;
                n_state   = rsef_pkg::ST_ABSD;
            end
            rsef_pkg::ST_ABSD: begin
                w_req.a   = '0;
                w_req.b   = {{(AW-RW){w_cfg.denominator[RW-1]}}, w_cfg.denominator};
                w_req.sub = 1'b1;
                n_md      = r_dn ? w_sum[RW-1:0] : w_cfg.denominator;
                n_rem     = '0;
                n_cnt     = '0;
                n_state   = rsef_pkg::ST_DIV;
            end
            rsef_pkg::ST_DIV: begin
                // restoring step: quotient bit shifts in where dividend bit left
                w_req.a   = {{(AW-RW-1){1'b0}}, w_shl};
                w_req.b   = {{(AW-RW){1'b0}}, r_md};
                w_req.sub = 1'b1;
                n_rem     = w_ge ? w_sum[RW-1:0] : w_shl[RW-1:0];
                n_acc     = {r_acc[AW-2:0], w_ge};
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CW'(rsef_pkg::DIV_STEPS - 1)) begin
                    n_state = rsef_pkg::ST_NEGQ;
                end
            end
            rsef_pkg::ST_NEGQ: begin
                w_req.a   = '0;
                w_req.b   = r_acc;
                w_req.sub = 1'b1;
                n_acc     = (r_tn ^ r_dn) ? w_sum : r_acc;
                n_state   = rsef_pkg::ST_NEGR;
            end
            rsef_pkg::ST_NEGR: begin
                // remainder takes the dividend's sign
                w_req.a   = '0;
                w_req.b   = {{(AW-RW){1'b0}}, r_rem};
                w_req.sub = 1'b1;
                n_carried = r_tn ? w_sum[RW-1:0] : r_rem;
                n_state   = rsef_pkg::ST_ADDC;
            end
            rsef_pkg::ST_ADDC: begin
                w_req.b = {{(AW-RW){w_cfg.center[RW-1]}}, w_cfg.center};
                if (w_out_free) begin
                    n_out     = w_sum;
                    n_out_vld = 1'b1;
                    n_state   = rsef_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rsef_pkg::ST_IDLE;
            end
        endcase
    end

    // each restoring step leaves the partial remainder below the divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsef_pkg::ST_DIV) |=> (r_rem < r_md))
        else $error("partial remainder not below divisor");

    // a zero denominator bypasses the divider
    a_zero_den_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsef_pkg::ST_ADDREM && w_cfg.denominator == '0)
            |=> (r_state == rsef_pkg::ST_ADDC))
        else $error("zero denominator entered division");

    // a waiting result is never overwritten by the next item
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsef_pkg::ST_ADDC && r_out_vld && !o_result.ready)
            |=> (r_state == rsef_pkg::ST_ADDC && r_out_vld))
        else $error("result register overwritten while stalled");

    // carried remainder only changes at the remainder step
    a_rem_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rsef_pkg::ST_NEGR) |=> $stable(r_carried))
        else $error("carried remainder changed outside remainder step");

endmodule

@@ sim/rational_scaler_error_feedback_top_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rational_scaler_error_feedback_top_tb - self-checking bench for the scaler
// Drives sample items and register writes, predicts each scaled value with a
// behavioral copy of the datapath and remainder state, and compares it with
// every result item. The sender bursts and pauses, and the result side stalls
// on its own random pattern.
// ============================================================================
module rational_scaler_error_feedback_top_tb;

    localparam int ACC_W     = rsef_pkg::ACC_W;
    localparam int REG_W     = rsef_pkg::REG_W;
    localparam int CFG_IDX_W = rsef_pkg::CFG_IDX_W;

    localparam int SAMPLE_W       = 32;
    localparam int RANDOM_ITEMS   = 1730;
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on any channel
    localparam int TAIL_CYCLES    = 120;   // a bit more than one full item latency

    // Register indexes past the last defined one; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED =
        CFG_IDX_W'(rsef_pkg::CFG_CARRY + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX   = '1;

    localparam logic [REG_W-1:0] REG_MAX = {1'b0, {(REG_W-1){1'b1}}};
    localparam logic [REG_W-1:0] REG_MIN = {1'b1, {(REG_W-1){1'b0}}};

    logic i_clk = 1'b0;
    logic i_rst_n;

    rsef_in_if #(.VALUE_WIDTH(SAMPLE_W)) smp_if ();
    rsef_out_if                          res_if ();
    rsef_cfg_if                          cfg_if ();

    rational_scaler_error_feedback_top #(
        .VALUE_WIDTH(SAMPLE_W)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: shadow copy of the registers plus the carried
    // remainder. The bench writes registers only while the block is idle (not
    // enforced by the block), so the shadow is each accepted item's setting.
    // ------------------------------------------------------------------------
    rsef_pkg::t_cfg          cfg_shadow;
    logic signed [REG_W-1:0] carried_rem;
    logic [ACC_W-1:0]        pending_scaled[$];

    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned bypass_items   = 0;   // zero denominator, no divide
    int unsigned carry_items    = 0;   // remainder fed back
    int unsigned settings_used  = 0;
    int unsigned idle_cycles    = 0;

    // Scale one sample under the current shadow setting; updates the carried
    // remainder exactly when a divide happens.
    function automatic logic [ACC_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] raw);
        logic [ACC_W-1:0] ctr;
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] dvs;
        logic [ACC_W-1:0] mag_a;
        logic [ACC_W-1:0] mag_d;
        logic [ACC_W-1:0] quo;
        logic [ACC_W-1:0] rem;
        logic             neg_a;
        logic             neg_d;
        ctr = {{(ACC_W-REG_W){cfg_shadow.center[REG_W-1]}}, cfg_shadow.center};
        acc = {{(ACC_W-SAMPLE_W){raw[SAMPLE_W-1]}}, raw} - ctr;
        // low 64 bits of the product are the same signed or unsigned
        acc = acc * {{(ACC_W-REG_W){cfg_shadow.numerator[REG_W-1]}}, cfg_shadow.numerator};
        if (cfg_shadow.carry) begin
            acc = acc + {{(ACC_W-REG_W){carried_rem[REG_W-1]}}, carried_rem};
        end
        if (cfg_shadow.denominator != '0) begin
            dvs   = {{(ACC_W-REG_W){cfg_shadow.denominator[REG_W-1]}},
                     cfg_shadow.denominator};
            neg_a = acc[ACC_W-1];
            neg_d = dvs[ACC_W-1];
            mag_a = neg_a ? -acc : acc;
            mag_d = neg_d ? -dvs : dvs;
            quo   = mag_a / mag_d;
            rem   = mag_a % mag_d;
            // truncation toward zero: remainder follows the dividend's sign
            if (neg_a != neg_d) begin
                quo = -quo;
            end
            if (neg_a) begin
                rem = -rem;
            end
            carried_rem = rem[REG_W-1:0];
            acc         = quo;
        end
        return acc + ctr;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers. Inputs change on the falling edge; handshakes are
    // taken from the rising edge.
    // ------------------------------------------------------------------------

    // Present one sample item and wait until it is taken. Valid stays high
    // afterwards so that back-to-back calls stream without a bubble.
    task automatic push_sample(input logic [SAMPLE_W-1:0] value);
        @(negedge i_clk);
        smp_if.valid        = 1'b1;
        smp_if.sample_value = value;
        do @(posedge i_clk); while (!smp_if.ready);
        if (cfg_shadow.denominator == '0) begin
            bypass_items++;
        end
        if (cfg_shadow.carry) begin
            carry_items++;
        end
        pending_scaled.push_back(scale_sample(value));
        items_sent++;
    endtask

    // Drop valid, with junk on the payload; n (n >= 1) sets the gap length.
    task automatic rest_sender(input int n);
        @(negedge i_clk);
        smp_if.valid        = 1'b0;
        smp_if.sample_value = $urandom;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Wait until every predicted result has come back: the block is idle.
    task automatic wait_results_done();
        rest_sender(1);
        while (pending_scaled.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            rsef_pkg::CFG_NUMERATOR:   cfg_shadow.numerator   = data;
            rsef_pkg::CFG_DENOMINATOR: cfg_shadow.denominator = data;
            rsef_pkg::CFG_CENTER:      cfg_shadow.center      = data;
            rsef_pkg::CFG_CARRY:       cfg_shadow.carry       = data[0];
            default:                   ;  // unused index, block must ignore it
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_IDX_W'($urandom);
        cfg_if.data  = $urandom;
    endtask

    // Register value biased toward the corners: zero, +-1, both extremes.
    function automatic logic [REG_W-1:0] pick_reg_value();
        logic [REG_W-1:0] v;
        case ($urandom_range(0, 8))
            0:       v = REG_MIN;
            1:       v = REG_MAX;
            2:       v = '0;
            3:       v = 1;
            4:       v = '1;
            5:       v = $urandom_range(1, 100);
            6:       v = -$urandom_range(1, 100);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall pattern - open windows on half of the picks, some short
    // stalls, now and then one about as long as a whole item or longer, so
    // that a finished item has to wait in the result register while the next
    // is in work.
    int unsigned stall_left = 0;

    always @(negedge i_clk) begin
        int unsigned pick;
        if (stall_left == 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 10) begin
                res_if.ready <= 1'b1;
                stall_left   = $urandom_range(1, 40);
            end else if (pick < 16) begin
                res_if.ready <= 1'b0;
                stall_left   = $urandom_range(1, 8);
            end else if (pick < 19) begin
                res_if.ready <= 1'b0;
                stall_left   = $urandom_range(9, 30);
            end else begin
                res_if.ready <= 1'b0;
                stall_left   = $urandom_range(100, 160);
            end
        end else begin
            stall_left = stall_left - 1;
        end
    end

    // Result checker: every result item against the oldest prediction.
    always @(posedge i_clk) begin
        logic [ACC_W-1:0] want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (pending_scaled.size() == 0) begin
                $error("scaled_value: no item outstanding, got %0d",
                       $signed(res_if.scaled_value));
                mismatch_count++;
            end else begin
                want = pending_scaled.pop_front();
                if (res_if.scaled_value !== want) begin
                    $error("scaled_value: expected %0d, got %0d",
                           $signed(want), $signed(res_if.scaled_value));
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: the longest legal quiet stretch is a sender gap plus one
    // item of work plus one long result stall.
    always @(posedge i_clk) begin
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d items still pending",
                     WATCHDOG_LIMIT, pending_scaled.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset setting is numerator 1, denominator 1, center 0: identity.
    task automatic test_reset_defaults();
        push_sample('0);
        push_sample(1);
        push_sample('1);
        push_sample(REG_MAX);
        push_sample(REG_MIN);
    endtask

    // Remainder feedback with a small divisor, then a divide by the most
    // negative divisor that leaves the largest negative remainder behind.
    task automatic test_remainder_carry();
        wait_results_done();
        write_reg(rsef_pkg::CFG_NUMERATOR, 1);
        write_reg(rsef_pkg::CFG_DENOMINATOR, 3);
        write_reg(rsef_pkg::CFG_CENTER, '0);
        write_reg(rsef_pkg::CFG_CARRY, 1);
        push_sample(1);
        push_sample(1);
        push_sample(1);
        push_sample('1);
        wait_results_done();
        write_reg(rsef_pkg::CFG_DENOMINATOR, REG_MIN);
        write_reg(rsef_pkg::CFG_CARRY, '0);
        push_sample(REG_MIN + 1);
    endtask

    // Zero denominator: no divide, the carried remainder must survive as is.
    task automatic test_zero_denominator();
        wait_results_done();
        write_reg(rsef_pkg::CFG_DENOMINATOR, '0);
        write_reg(rsef_pkg::CFG_NUMERATOR, REG_MAX);
        write_reg(rsef_pkg::CFG_CENTER, REG_MIN);
        write_reg(rsef_pkg::CFG_CARRY, 1);
        push_sample(REG_MAX);
        push_sample(REG_MIN);
    endtask

    // Largest product magnitudes. With the remainder left above, the
    // dividend lands one above the most negative 64-bit value and is divided
    // by minus one - the closest the inputs can come to the wrapping case.
    task automatic test_extreme_scaling();
        wait_results_done();
        write_reg(rsef_pkg::CFG_NUMERATOR, REG_MIN);
        write_reg(rsef_pkg::CFG_DENOMINATOR, '1);
        push_sample(REG_MAX);
        push_sample(REG_MIN);
        wait_results_done();
        write_reg(rsef_pkg::CFG_NUMERATOR, REG_MAX);
        write_reg(rsef_pkg::CFG_DENOMINATOR, REG_MAX);
        write_reg(rsef_pkg::CFG_CARRY, '0);
        push_sample(REG_MAX);
        push_sample(REG_MIN);
    endtask

    // Writes to undefined indexes and to upper bits of the carry flag must
    // leave the setting alone.
    task automatic test_ignored_writes();
        wait_results_done();
        write_reg(CFG_FIRST_UNUSED, $urandom);
        write_reg(CFG_LAST_INDEX, $urandom);
        write_reg(rsef_pkg::CFG_CARRY, {{(REG_W-1){1'b1}}, 1'b0});
        push_sample($urandom);
        push_sample($urandom);
    endtask

    // Random settings in phases; random samples streamed in bursts.
    task automatic test_random_phases();
        int unsigned      sent;
        int unsigned      phase_len;
        int unsigned      burst_left;
        int unsigned      gap;
        logic [REG_W-1:0] value;
        sent       = 0;
        burst_left = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_results_done();
            write_reg(rsef_pkg::CFG_NUMERATOR, pick_reg_value());
            write_reg(rsef_pkg::CFG_DENOMINATOR, pick_reg_value());
            write_reg(rsef_pkg::CFG_CENTER, pick_reg_value());
            write_reg(rsef_pkg::CFG_CARRY, $urandom);
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX)),
                          $urandom);
            end
            settings_used++;
            phase_len = $urandom_range(10, 80);
            repeat (phase_len) begin
                if (burst_left == 0) begin
                    // gaps long enough to land on every stage of the divide
                    case ($urandom_range(0, 3))
                        0:       gap = 0;
                        1:       gap = $urandom_range(1, 5);
                        default: gap = $urandom_range(1, 110);
                    endcase
                    if (gap != 0) begin
                        rest_sender(gap);
                    end
                    burst_left = $urandom_range(1, 12);
                end
                burst_left--;
                case ($urandom_range(0, 9))
                    0:       value = REG_MAX;
                    1:       value = REG_MIN;
                    2:       value = $urandom_range(0, 2) - 1;
                    3, 4:    value = cfg_shadow.center + $urandom_range(0, 200) - 100;
                    default: value = $urandom;
                endcase
                push_sample(value);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        smp_if.valid        = 1'b0;
        smp_if.sample_value = '0;
        res_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;

        cfg_shadow.numerator   = 1;
        cfg_shadow.denominator = 1;
        cfg_shadow.center      = '0;
        cfg_shadow.carry       = 1'b0;
        carried_rem            = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_remainder_carry();
        test_zero_denominator();
        test_extreme_scaling();
        test_ignored_writes();
        test_random_phases();

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("checked %0d of %0d scaled items over %0d random settings",
                 results_seen, items_sent, settings_used);
        $display("%0d items bypassed the divide, %0d fed the remainder back",
                 bypass_items, carry_items);
        if (mismatch_count == 0 && pending_scaled.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rsef_pkg.sv
rtl/rsef_if.sv
rtl/rsef_cfg.sv
rtl/rsef_alu.sv
rtl/rational_scaler_error_feedback_top.sv
sim/rational_scaler_error_feedback_top_tb.sv
